[hdl/ip_address_text_parser_macros.svh]
// Assertion macros for the host text parser.
`ifndef IP_ADDRESS_TEXT_PARSER_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IATP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IATP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ipatp_pkg.sv]
// Types and character constants shared by the host text parser.
package ipatp_pkg;

	typedef enum logic [1:0] {
		KIND_IPV4 = 2'd0,
		KIND_IPV6 = 2'd1,
		KIND_NAME = 2'd2
	} kind_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;

	// flag bit positions
	localparam int unsigned FLAG_COLON   = 0;
	localparam int unsigned FLAG_LETTER  = 1;
	localparam int unsigned FLAG_PENDING = 2;
	localparam int unsigned FLAG_DOUBLE  = 3;

	localparam logic [3:0] COUNT_MAX     = 4'd15;
	localparam logic [3:0] GROUPS_IPV6   = 4'd8;
	localparam logic [3:0] COLONS_LIMIT  = 4'd7;

endpackage

[hdl/ip_address_text_parser.sv]
// Host text parser: one character per word in, kind and 128-bit address out on the last one.
// Takes one character word per cycle while in_ready is high: each word is captured in an input
// register and, when it advances, updates the decimal and hex accumulators; on the word marked
// last the kind, the 128-bit value and the colon overflow flag are loaded into the output
// register instead, so out_valid rises as the last word moves from the input register to the
// output register. With a double colon the hex value is formed by placing the head part with a
// 16-bit-step shifter (double colon gap plus groups after it) and ORing in the tail part and
// final group. A stalled result only holds back the input when the next word is itself a last
// character; all accumulators clear after each result.
`include "ip_address_text_parser_macros.svh"

module ip_address_text_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       ch,
	input  logic             last,
	input  logic             in_valid,
	output logic             in_ready,
	output ipatp_pkg::kind_t kind,
	output logic [63:0]      addr_high,
	output logic [63:0]      addr_low,
	output logic             too_many_colons,
	output logic             out_valid,
	input  logic             out_ready
);
	import ipatp_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       adv;

	// accumulators
	logic [127:0] dotted_value_q, hex_head_q, hex_tail_q;
	logic [15:0]  dotted_group_q, hex_group_q;
	logic [3:0]   colon_count_q, tail_shift_q, flags_q;

	logic [127:0] dotted_value_n, hex_head_n, hex_tail_n, acc_sel, acc_shl;
	logic [15:0]  dotted_group_n, hex_group_n, hex_ref;
	logic [3:0]   colon_count_n, tail_shift_n, flags_n, gap;
	logic [4:0]   units;
	logic [127:0] head_placed, result_val;
	logic         is_letter;
	kind_t        kind_n;

	// output register
	logic         out_valid_q;
	kind_t        kind_q;
	logic [127:0] addr_q;
	logic         flag_q;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	always_comb begin
		is_letter = (ch_s1 >= CH_LC_A && ch_s1 <= CH_LC_Z) ||
			(ch_s1 >= CH_UC_A && ch_s1 <= CH_UC_Z);

		dotted_value_n = dotted_value_q;
		dotted_group_n = dotted_group_q;
		hex_head_n     = hex_head_q;
		hex_tail_n     = hex_tail_q;
		hex_group_n    = hex_group_q;
		colon_count_n  = colon_count_q;
		tail_shift_n   = tail_shift_q;
		flags_n        = flags_q;
		if (is_letter) begin
			flags_n[FLAG_LETTER] = 1'b1;
		end

		// decimal reading
		if (ch_s1 == CH_DOT) begin
			dotted_value_n = {dotted_value_q[119:16],
				dotted_value_q[15:0] | dotted_group_q, 8'h00};
			dotted_group_n = '0;
		end else begin
			dotted_group_n = {dotted_group_q[12:0], 3'b000} + {dotted_group_q[14:0], 1'b0}
				+ {8'h00, ch_s1} - {8'h00, CH_ZERO};
		end

		// hex reading
		acc_sel = flags_q[FLAG_DOUBLE] ? hex_tail_q : hex_head_q;
		acc_shl = {acc_sel[111:16], acc_sel[15:0] | hex_group_q, 16'h0000};
		if (ch_s1 >= CH_LC_A && ch_s1 <= CH_LC_F) begin
			hex_ref = {8'h00, CH_LC_A};
		end else if (ch_s1 >= CH_UC_A && ch_s1 <= CH_UC_F) begin
			hex_ref = {8'h00, CH_UC_A};
		end else begin
			hex_ref = {8'h00, CH_ZERO};
		end
		if (ch_s1 == CH_COLON) begin
			flags_n[FLAG_COLON] = 1'b1;
			if (colon_count_q < COUNT_MAX) begin
				colon_count_n = colon_count_q + 4'd1;
			end
			if (flags_q[FLAG_PENDING]) begin
				// second half of a double colon
				flags_n[FLAG_PENDING] = 1'b0;
				flags_n[FLAG_DOUBLE]  = 1'b1;
			end else begin
				if (flags_q[FLAG_DOUBLE]) begin
					hex_tail_n = acc_shl;
					if (tail_shift_q < COUNT_MAX) begin
						tail_shift_n = tail_shift_q + 4'd1;
					end
				end else begin
					hex_head_n = acc_shl;
				end
				hex_group_n = '0;
				flags_n[FLAG_PENDING] = 1'b1;
			end
		end else begin
			hex_group_n = {hex_group_q[11:0], 4'h0} + {8'h00, ch_s1} - hex_ref;
			flags_n[FLAG_PENDING] = 1'b0;
		end

		// result
		gap   = (colon_count_n <= GROUPS_IPV6) ? (GROUPS_IPV6 - colon_count_n) : 4'd0;
		units = {1'b0, gap} + {1'b0, tail_shift_n};
		if (units[4:3] != 2'b00) begin
			head_placed = '0;
		end else begin
			head_placed = hex_head_n << {units[2:0], 4'h0};
		end
		if (flags_n[FLAG_COLON]) begin
			kind_n     = KIND_IPV6;
			result_val = flags_n[FLAG_DOUBLE] ? (head_placed | hex_tail_n) : hex_head_n;
			result_val[15:0] = result_val[15:0] | hex_group_n;
		end else if (flags_n[FLAG_LETTER]) begin
			kind_n     = KIND_NAME;
			result_val = '0;
		end else begin
			kind_n     = KIND_IPV4;
			result_val = {dotted_value_n[127:16], dotted_value_n[15:0] | dotted_group_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dotted_value_q <= '0;
			dotted_group_q <= '0;
			hex_head_q     <= '0;
			hex_tail_q     <= '0;
			hex_group_q    <= '0;
			colon_count_q  <= '0;
			tail_shift_q   <= '0;
			flags_q        <= '0;
		end else if (adv) begin
			if (last_s1) begin
				dotted_value_q <= '0;
				dotted_group_q <= '0;
				hex_head_q     <= '0;
				hex_tail_q     <= '0;
				hex_group_q    <= '0;
				colon_count_q  <= '0;
				tail_shift_q   <= '0;
				flags_q        <= '0;
			end else begin
				dotted_value_q <= dotted_value_n;
				dotted_group_q <= dotted_group_n;
				hex_head_q     <= hex_head_n;
				hex_tail_q     <= hex_tail_n;
				hex_group_q    <= hex_group_n;
				colon_count_q  <= colon_count_n;
				tail_shift_q   <= tail_shift_n;
				flags_q        <= flags_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			kind_q <= kind_n;
			addr_q <= result_val;
			flag_q <= (colon_count_n > COLONS_LIMIT);
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign addr_high       = addr_q[127:64];
	assign addr_low        = addr_q[63:0];
	assign too_many_colons = flag_q;

	`IATP_ASSERT_NOW(a_name_zero, out_valid && kind == KIND_NAME, addr_q == '0, "name not zero")
	`IATP_ASSERT_NOW(a_flag_ipv6, out_valid && too_many_colons, kind == KIND_IPV6, "flag not ipv6")
	`IATP_ASSERT_NOW(a_colon_flag, 1'b1, |colon_count_q == flags_q[FLAG_COLON], "colon flag")
	`IATP_ASSERT_NOW(a_tail_double, tail_shift_q != 4'd0, flags_q[FLAG_DOUBLE], "tail, no double")
	`IATP_ASSERT_NEXT(a_clear_after_last, adv && last_s1, ~|{colon_count_q, flags_q}, "not cleared")

endmodule
